FILE: sv/lzsswd_pkg.sv
// Shared types and constants for the LZSS window decoder.
`timescale 1ns / 1ps

package lzsswd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = ADDR_W + 1;
    localparam int LEN_W        = 24;
    localparam int CNT_W        = 5;
    localparam int FLAG_W       = 9;

    localparam logic [ADDR_W-1:0] WP_START  = ADDR_W'(12'hFEE);
    localparam logic [7:0]        FILL_BYTE = 8'hFF;
    localparam logic [CNT_W-1:0]  LEN_BIAS  = CNT_W'(3);
    localparam logic [CNT_W-1:0]  MAX_LEN   = CNT_W'(18);
    localparam logic [LEN_W-1:0]  OUT_LENGTH_RESET = LEN_W'(1);

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_MATCH_HI
    } t_phase;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_win_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_win_rd;

endpackage

FILE: sv/lzsswd_window.sv
// History window RAM with fill tracking and write-to-read forwarding.
`timescale 1ns / 1ps

module lzsswd_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  lzsswd_pkg::t_win_wr       i_wr,
    input  lzsswd_pkg::t_win_rd       i_rd,
    output logic [7:0]                o_rd_data
);

    logic [7:0] r_mem [lzsswd_pkg::WINDOW_DEPTH];
    logic [7:0] r_mem_q;
    logic       r_fwd;
    logic [7:0] r_fwd_data;
    logic       r_rd_ok;

    logic [lzsswd_pkg::FILL_W-1:0] r_fill;
    logic [lzsswd_pkg::FILL_W-1:0] n_fill;
    logic [lzsswd_pkg::ADDR_W-1:0] rd_offset;
    logic                          rd_ok;
    logic                          rd_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_mem_q <= r_mem[i_rd.addr];
        end
    end

    always_comb begin
        rd_offset = i_rd.addr - lzsswd_pkg::WP_START;
        rd_ok     = {1'b0, rd_offset} < r_fill;
        rd_fwd    = i_wr.en && (i_wr.addr == i_rd.addr);
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_fwd      <= rd_fwd;
            r_fwd_data <= i_wr.data;
            r_rd_ok    <= rd_ok;
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_clear) begin
            n_fill = '0;
        end else if (i_wr.en && (r_fill != lzsswd_pkg::FILL_W'(lzsswd_pkg::WINDOW_DEPTH))) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_rd_data = r_fwd   ? r_fwd_data :
                       r_rd_ok ? r_mem_q    : lzsswd_pkg::FILL_BYTE;

endmodule

FILE: sv/lzss_window_decoder.sv
// Top level of the LZSS decoder: token parser, copy engine and output register.
`timescale 1ns / 1ps

// Takes one compressed byte per input word and emits decompressed bytes, one
// per output word. A flag byte or a first match byte is taken and gives no
// output. A literal gives one byte, and the next input word is accepted once
// that byte has left stage s1. A match of length L (3 to 18) streams L bytes
// at one byte per cycle while the output side keeps up, through the single
// read port of the 4096-byte window RAM, so the next input word is accepted
// only once all L reads are issued and stage s1 is empty; output stalls
// hold the stream. The window needs no clearing pass after reset or restart:
// a fill count marks which entries were written since, and unwritten entries
// read as 0xFF. Once out_length bytes have been produced the match is cut
// short, done_res is raised on that byte, and later words are consumed
// without output until a word with restart set.

module lzss_window_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_done_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_out_length
);

    localparam int AW = lzsswd_pkg::ADDR_W;

    lzsswd_pkg::t_phase r_phase, n_phase;
    logic [lzsswd_pkg::FLAG_W-1:0] r_flags, n_flags;
    logic [7:0]                    r_low, n_low;
    logic [AW-1:0]                 r_wp, n_wp;
    logic [AW-1:0]                 r_pos, n_pos;
    logic [lzsswd_pkg::LEN_W-1:0]  r_emitted, n_emitted;
    logic [lzsswd_pkg::LEN_W-1:0]  r_out_length, n_out_length;
    logic                          r_finished, n_finished;
    logic [lzsswd_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                          r_s1_valid, n_s1_valid;
    logic                          r_s1_lit, n_s1_lit;
    logic [7:0]                    r_s1_byte, n_s1_byte;
    logic                          r_s1_last, n_s1_last;
    logic                          r_out_valid, n_out_valid;
    logic [7:0]                    r_out_byte, n_out_byte;
    logic                          r_out_last, n_out_last;
    logic                          r_out_done, n_out_done;

    logic                          in_fire;
    logic                          restart_fire;
    logic                          act;
    lzsswd_pkg::t_phase            eff_phase;
    logic [lzsswd_pkg::FLAG_W-1:0] flags_adv;
    logic                          adv_to_flag;
    logic                          out_free;
    logic                          s1_fire;
    logic [lzsswd_pkg::LEN_W-1:0]  emitted_inc;
    logic                          fire_done;
    logic                          kill;
    logic                          rd_issue;
    logic [7:0]                    s1_data;
    logic [7:0]                    win_q;

    lzsswd_pkg::t_win_wr win_wr;
    lzsswd_pkg::t_win_rd win_rd;

    always_comb begin
        o_in_ready   = (r_cnt == '0) && !r_s1_valid;
        in_fire      = i_in_valid && o_in_ready;
        restart_fire = in_fire && i_restart;
        eff_phase    = i_restart ? lzsswd_pkg::PH_FLAG : r_phase;
        act          = in_fire && (i_restart || !r_finished);
        flags_adv    = r_flags >> 1;
        adv_to_flag  = flags_adv <= lzsswd_pkg::FLAG_W'(1);
        out_free     = !r_out_valid || i_out_ready;
        s1_fire      = r_s1_valid && out_free;
        emitted_inc  = r_emitted + 1'b1;
        fire_done    = emitted_inc >= r_out_length;
        kill         = s1_fire && fire_done;
        rd_issue     = (r_cnt != '0) && (!r_s1_valid || s1_fire) && !kill;
        s1_data      = r_s1_lit ? r_s1_byte : win_q;
    end

    always_comb begin
        win_wr.en   = s1_fire;
        win_wr.addr = r_wp;
        win_wr.data = s1_data;
        win_rd.en   = rd_issue;
        win_rd.addr = r_pos;
    end

    lzsswd_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (restart_fire),
        .i_wr      (win_wr),
        .i_rd      (win_rd),
        .o_rd_data (win_q)
    );

    // next state of the token parser
    always_comb begin
        n_phase = r_phase;
        n_flags = r_flags;
        if (restart_fire) begin
            n_phase = lzsswd_pkg::PH_FLAG;
            n_flags = '0;
        end
        if (act) begin
            case (eff_phase)
                lzsswd_pkg::PH_FLAG: begin
                    n_flags = {1'b1, i_in_byte};
                    n_phase = lzsswd_pkg::PH_TOKEN;
                end
                lzsswd_pkg::PH_TOKEN: begin
                    if (r_flags[0]) begin
                        n_flags = adv_to_flag ? '0 : flags_adv;
                        n_phase = adv_to_flag ? lzsswd_pkg::PH_FLAG : lzsswd_pkg::PH_TOKEN;
                    end else begin
                        n_phase = lzsswd_pkg::PH_MATCH_HI;
                    end
                end
                lzsswd_pkg::PH_MATCH_HI: begin
                    n_flags = adv_to_flag ? '0 : flags_adv;
                    n_phase = adv_to_flag ? lzsswd_pkg::PH_FLAG : lzsswd_pkg::PH_TOKEN;
                end
                default: begin
                    n_flags = '0;
                    n_phase = lzsswd_pkg::PH_FLAG;
                end
            endcase
        end
    end

    // datapath and copy engine
    always_comb begin
        n_low        = r_low;
        n_wp         = r_wp;
        n_pos        = r_pos;
        n_emitted    = r_emitted;
        n_finished   = r_finished;
        n_out_length = r_out_length;
        n_cnt        = r_cnt;
        n_s1_valid   = r_s1_valid;
        n_s1_lit     = r_s1_lit;
        n_s1_byte    = r_s1_byte;
        n_s1_last    = r_s1_last;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_done   = r_out_done;

        if (i_cfg_valid) begin
            n_out_length = i_cfg_out_length;
        end

        if (restart_fire) begin
            n_wp       = lzsswd_pkg::WP_START;
            n_emitted  = '0;
            n_finished = 1'b0;
        end

        if (s1_fire) begin
            n_wp        = r_wp + 1'b1;
            n_emitted   = emitted_inc;
            n_s1_valid  = 1'b0;
            n_out_valid = 1'b1;
            n_out_byte  = s1_data;
            n_out_last  = r_s1_last || fire_done;
            n_out_done  = fire_done;
            if (fire_done) begin
                n_finished = 1'b1;
                n_cnt      = '0;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (rd_issue) begin
            n_s1_valid = 1'b1;
            n_s1_lit   = 1'b0;
            n_s1_last  = (r_cnt == lzsswd_pkg::CNT_W'(1));
            n_cnt      = r_cnt - 1'b1;
            n_pos      = r_pos + 1'b1;
        end

        if (act) begin
            case (eff_phase)
                lzsswd_pkg::PH_TOKEN: begin
                    if (r_flags[0]) begin
                        n_s1_valid = 1'b1;
                        n_s1_lit   = 1'b1;
                        n_s1_byte  = i_in_byte;
                        n_s1_last  = 1'b1;
                    end else begin
                        n_low = i_in_byte;
                    end
                end
                lzsswd_pkg::PH_MATCH_HI: begin
                    n_pos = AW'({i_in_byte[7:4], r_low});
                    n_cnt = lzsswd_pkg::CNT_W'(i_in_byte[3:0]) + lzsswd_pkg::LEN_BIAS;
                end
                default: begin
                    n_low = r_low;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lzsswd_pkg::PH_FLAG;
            r_flags      <= '0;
            r_wp         <= lzsswd_pkg::WP_START;
            r_emitted    <= '0;
            r_finished   <= 1'b0;
            r_out_length <= lzsswd_pkg::OUT_LENGTH_RESET;
            r_cnt        <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_flags      <= n_flags;
            r_wp         <= n_wp;
            r_emitted    <= n_emitted;
            r_finished   <= n_finished;
            r_out_length <= n_out_length;
            r_cnt        <= n_cnt;
            r_s1_valid   <= n_s1_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low      <= n_low;
        r_pos      <= n_pos;
        r_s1_lit   <= n_s1_lit;
        r_s1_byte  <= n_s1_byte;
        r_s1_last  <= n_s1_last;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_done_res    = r_out_done;

    a_kill_stops_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        kill |=> (r_cnt == '0) && !r_s1_valid)
        else $error("copy continued after the run completed");

    a_finished_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_cnt == '0) && !r_s1_valid)
        else $error("copy engine busy while finished");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= lzsswd_pkg::MAX_LEN)
        else $error("copy count beyond maximum match length");

    a_flag_phase_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lzsswd_pkg::PH_FLAG) |-> (r_flags == '0))
        else $error("flag bits left while expecting a flag byte");

endmodule
